/* rtl/drle_pkg.sv */
// Package for the delta run-length encoder.
// Holds the fixed field widths, output queue sizing and the push control type.
// No dependencies.
package drle_pkg;

    // Width of the run_count field; holds any run length up to 255.
    localparam int COUNT_BITS = 8;

    // Output queue sizing. One item can push two pairs, so the encoder stage
    // only advances while at least two entries are free.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    // Pairs pushed by the encoder stage in one cycle. The first slot is
    // always filled before the second one.
    typedef struct packed {
        logic first;
        logic second;
    } push_ctl_t;

endpackage

/* rtl/drle_core.sv */
// Delta and run state of the encoder: differences one sample and merges runs.
// Depends on drle_pkg; produces zero, one or two packed pairs per item.
module drle_core
    import drle_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RUN = 255,
    parameter int PAIR_BITS = SAMPLE_BITS + 1 + COUNT_BITS + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last_sample,
    output push_ctl_t              push,
    output logic [PAIR_BITS-1:0]   push_data0,
    output logic [PAIR_BITS-1:0]   push_data1
);

    localparam int DELTA_BITS = SAMPLE_BITS + 1;
    localparam logic [COUNT_BITS-1:0] RUN_LIMIT = COUNT_BITS'(MAX_RUN);
    localparam logic [COUNT_BITS-1:0] ONE_COUNT = COUNT_BITS'(1);

    logic [SAMPLE_BITS-1:0] prev_sample_reg, prev_sample_next;
    logic [DELTA_BITS-1:0]  cur_delta_reg, cur_delta_next;
    logic [COUNT_BITS-1:0]  cur_count_reg, cur_count_next;
    logic                   run_open_reg, run_open_next;
    logic                   expect_base_reg, expect_base_next;

    logic [DELTA_BITS-1:0]  delta;
    logic                   extend;
    logic                   emit_old;
    logic                   emit_new;
    logic [DELTA_BITS-1:0]  new_delta;
    logic [COUNT_BITS-1:0]  new_count;
    logic [PAIR_BITS-1:0]   old_pair;
    logic [PAIR_BITS-1:0]   new_pair;

    always_comb
    begin
        delta = {sample[SAMPLE_BITS-1], sample}
              - {prev_sample_reg[SAMPLE_BITS-1], prev_sample_reg};
        extend = run_open_reg && (delta == cur_delta_reg) && (cur_count_reg < RUN_LIMIT);
        new_delta = extend ? cur_delta_reg : delta;
        new_count = extend ? cur_count_reg + ONE_COUNT : ONE_COUNT;
        emit_old = !expect_base_reg && run_open_reg && !extend;
        emit_new = !expect_base_reg && ((new_count >= RUN_LIMIT) || last_sample);

        // Packed pair: delta in the low bits, then count, then end of block.
        old_pair = {1'b0, cur_count_reg, cur_delta_reg};
        new_pair = {last_sample, new_count, new_delta};

        push.first  = fire && (emit_old || emit_new);
        push.second = fire && emit_old && emit_new;
        push_data0  = emit_old ? old_pair : new_pair;
        push_data1  = new_pair;

        prev_sample_next = prev_sample_reg;
        cur_delta_next   = cur_delta_reg;
        cur_count_next   = cur_count_reg;
        run_open_next    = run_open_reg;
        expect_base_next = expect_base_reg;
        if (fire)
        begin
            prev_sample_next = sample;
            if (expect_base_reg)
            begin
                // A base sample that is also the last one leaves the block empty.
                expect_base_next = last_sample;
            end
            else
            begin
                cur_delta_next   = new_delta;
                cur_count_next   = new_count;
                run_open_next    = !emit_new;
                expect_base_next = last_sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            cur_delta_reg   <= '0;
            cur_count_reg   <= '0;
            run_open_reg    <= 1'b0;
            expect_base_reg <= 1'b1;
        end
        else
        begin
            prev_sample_reg <= prev_sample_next;
            cur_delta_reg   <= cur_delta_next;
            cur_count_reg   <= cur_count_next;
            run_open_reg    <= run_open_next;
            expect_base_reg <= expect_base_next;
        end
    end

endmodule

/* rtl/drle_queue.sv */
// Small output queue for encoded pairs; takes up to two pairs per cycle.
// Depends on drle_pkg for its sizing and the push control type.
module drle_queue
    import drle_pkg::*;
#(
    parameter int PAIR_BITS = 26
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  push_ctl_t            push,
    input  logic [PAIR_BITS-1:0] push_data0,
    input  logic [PAIR_BITS-1:0] push_data1,
    input  logic                 pop,
    output logic                 room,
    output logic                 not_empty,
    output logic [PAIR_BITS-1:0] head
);

    localparam logic [QUEUE_CNT_BITS-1:0] ROOM_LIMIT = QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
    localparam logic [QUEUE_PTR_BITS-1:0] PTR_ONE = QUEUE_PTR_BITS'(1);

    logic [PAIR_BITS-1:0]      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic [QUEUE_CNT_BITS-1:0] push_n;

    always_comb
    begin
        push_n      = QUEUE_CNT_BITS'(push.first) + QUEUE_CNT_BITS'(push.second);
        wr_ptr_next = wr_ptr_reg + push_n[QUEUE_PTR_BITS-1:0];
        rd_ptr_next = rd_ptr_reg + (pop ? PTR_ONE : '0);
        count_next  = count_reg + push_n - (pop ? QUEUE_CNT_BITS'(1) : '0);
        room        = count_reg <= ROOM_LIMIT;
        not_empty   = count_reg != '0;
        head        = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push.second)
        begin
            entry_reg[wr_ptr_reg + PTR_ONE] <= push_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/delta_run_length_encoder.sv */
// Top level of the delta run-length encoder: input register, encoder, output queue.
// Depends on drle_pkg, drle_core and drle_queue.
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   s_tvalid/s_tready  tdata: sample; tlast: last_sample
//  m_*      out  m_tvalid/m_tready  tdata: run_delta, run_count; tlast: end_of_block
//
// One item is taken per cycle while the output queue has room. An item waits in the
// input register while the encoder works on it; the encoder writes all of its pairs
// into the queue in the same cycle, and they leave on m_* in order from the queue head.
// The four-entry output queue sets the pace: the encoder advances only while at least two
// entries are free, so s_tready drops when m_tready stalls long enough.
// Reset is asynchronous and leaves the encoder expecting a base sample.
module delta_run_length_encoder
    import drle_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RUN = 255
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // Bits from low: sample, zero fill.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]               s_tdata,
    input  logic                                           s_tlast,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // Bits from low: run_delta, run_count, zero fill.
    output logic [((SAMPLE_BITS+1+COUNT_BITS+7)/8)*8-1:0]  m_tdata,
    output logic                                           m_tlast
);

    localparam int DELTA_BITS = SAMPLE_BITS + 1;
    localparam int PAIR_BITS = DELTA_BITS + COUNT_BITS + 1;
    localparam int OUT_BITS = ((DELTA_BITS + COUNT_BITS + 7) / 8) * 8;

    logic                   in_vld_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_last_reg;
    logic                   advance;
    logic                   room;
    logic                   not_empty;
    push_ctl_t              push;
    logic [PAIR_BITS-1:0]   push_data0;
    logic [PAIR_BITS-1:0]   push_data1;
    logic [PAIR_BITS-1:0]   head;

    assign advance  = in_vld_reg && room;
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    drle_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_RUN     (MAX_RUN),
        .PAIR_BITS   (PAIR_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .sample      (in_sample_reg),
        .last_sample (in_last_reg),
        .push        (push),
        .push_data0  (push_data0),
        .push_data1  (push_data1)
    );

    drle_queue #(
        .PAIR_BITS (PAIR_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .pop        (m_tvalid && m_tready),
        .room       (room),
        .not_empty  (not_empty),
        .head       (head)
    );

    assign m_tvalid = not_empty;
    assign m_tdata  = OUT_BITS'(head[DELTA_BITS+COUNT_BITS-1:0]);
    assign m_tlast  = head[PAIR_BITS-1];

endmodule

/* rtl/drle_checker.sv */
// Port-level checks for the delta run-length encoder, bound to the top level.
// Depends on drle_pkg for the count field width.
module drle_checker
    import drle_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RUN = 255
)
(
    input logic                                           clk,
    input logic                                           rst_n,
    input logic                                           s_tvalid,
    input logic                                           s_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]               s_tdata,
    input logic                                           s_tlast,
    input logic                                           m_tvalid,
    input logic                                           m_tready,
    input logic [((SAMPLE_BITS+1+COUNT_BITS+7)/8)*8-1:0]  m_tdata,
    input logic                                           m_tlast
);

    localparam int CNT_LO = SAMPLE_BITS + 1;
    localparam int CNT_HI = CNT_LO + COUNT_BITS - 1;

    // A stalled pair stays put.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output pair changed while stalled");

    // Every emitted run holds at least one delta.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[CNT_HI:CNT_LO] != '0)
        else $error("run with zero count");

    // No run grows past the limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[CNT_HI:CNT_LO] <= COUNT_BITS'(MAX_RUN))
        else $error("run longer than the limit");

    // The first cycle out of reset has nothing to show, whatever arrives.
    a_quiet_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind delta_run_length_encoder drle_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RUN     (MAX_RUN)
) u_drle_checker (.*);

/* tb/tb_delta_run_length_encoder.sv */
// Self-checking testbench for delta_run_length_encoder: directed table, then random blocks.
// Each accepted sample runs through an internal run encoder; pairs are checked in order.
// Depends on drle_pkg and the delta_run_length_encoder RTL.
`timescale 1ns / 1ps

module tb_delta_run_length_encoder
    import drle_pkg::*;
();

    localparam int SAMPLE_W = 16;
    localparam int DELTA_W = SAMPLE_W + 1;
    localparam int S_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((DELTA_W + COUNT_BITS + 7) / 8) * 8;
    localparam int MAX_RUN = 255;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic [DELTA_W-1:0]    delta;
        logic [COUNT_BITS-1:0] count;
        logic                  eob;
    } run_pair_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                lst;
        logic                typed;
        logic [1:0]          n_pairs;
        run_pair_t           p0;
        run_pair_t           p1;
    } stim_row_t;

    typedef enum int {BLK_NOISE, BLK_RAMP, BLK_STEPS, BLK_EXTREME} block_kind_t;

    localparam run_pair_t NO_PAIR = '0;
    localparam int N_ROWS = 18;

    // Rows with typed set carry their pairs; the rest are left to the encoder model.
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{16'h0000, 1'b0, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'h7FFF, 1'b0, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'h8000, 1'b0, 1'b1, 2'd1, '{17'h07FFF, 8'd1, 1'b0}, NO_PAIR},
        '{16'h7FFF, 1'b0, 1'b1, 2'd1, '{17'h10001, 8'd1, 1'b0}, NO_PAIR},
        '{16'h7FFF, 1'b0, 1'b1, 2'd1, '{17'h0FFFF, 8'd1, 1'b0}, NO_PAIR},
        '{16'h7FFF, 1'b1, 1'b1, 2'd1, '{17'h00000, 8'd2, 1'b1}, NO_PAIR},
        '{16'd1234, 1'b1, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'hFFFB, 1'b0, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'hFFFD, 1'b1, 1'b1, 2'd1, '{17'h00002, 8'd1, 1'b1}, NO_PAIR},
        '{16'd100,  1'b0, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'd101,  1'b0, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'd102,  1'b0, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'd110,  1'b1, 1'b1, 2'd2, '{17'h00001, 8'd2, 1'b0}, '{17'h00008, 8'd1, 1'b1}},
        '{16'hFFFF, 1'b0, 1'b0, 2'd0, NO_PAIR, NO_PAIR},
        '{16'h0000, 1'b0, 1'b0, 2'd0, NO_PAIR, NO_PAIR},
        '{16'h0001, 1'b1, 1'b0, 2'd0, NO_PAIR, NO_PAIR},
        '{16'h8000, 1'b0, 1'b1, 2'd0, NO_PAIR, NO_PAIR},
        '{16'h8000, 1'b1, 1'b1, 2'd1, '{17'h00000, 8'd1, 1'b1}, NO_PAIR}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    delta_run_length_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Encoder model state.
    logic [SAMPLE_W-1:0]   prev_smp;
    logic [DELTA_W-1:0]    open_delta;
    logic [COUNT_BITS-1:0] open_len;
    logic                  open_run;
    logic                  want_base;

    run_pair_t runs_due [$];

    int errors = 0;
    int items_sent = 0;
    int blocks_sent = 0;
    int pairs_seen = 0;
    int full_runs = 0;
    int blocks_closed = 0;
    int input_stalls = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_asked = 0;
    int holds_done = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Advances the model by one sample and returns how many pairs it closes.
    function automatic int encode_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                                         output run_pair_t p0, output run_pair_t p1);
        logic [DELTA_W-1:0] d;
        run_pair_t          closing;
        int                 n;
        n = 0;
        p0 = NO_PAIR;
        p1 = NO_PAIR;
        if (want_base)
        begin
            prev_smp = smp;
            want_base = lst;
            return 0;
        end
        d = {smp[SAMPLE_W-1], smp} - {prev_smp[SAMPLE_W-1], prev_smp};
        prev_smp = smp;
        if (open_run && d == open_delta && open_len < MAX_RUN)
            open_len++;
        else
        begin
            if (open_run)
            begin
                p0 = '{open_delta, open_len, 1'b0};
                n = 1;
            end
            open_delta = d;
            open_len = COUNT_BITS'(1);
            open_run = 1'b1;
        end
        if (open_len >= MAX_RUN || lst)
        begin
            closing = '{open_delta, open_len, lst};
            if (n == 0)
                p0 = closing;
            else
                p1 = closing;
            n++;
            open_run = 1'b0;
        end
        if (lst)
            want_base = 1'b1;
        return n;
    endfunction

    // Presents one item, waits for the handshake, then records the pairs it is due to close.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                                input logic typed, input logic [1:0] n_typed,
                                input run_pair_t t0, input run_pair_t t1);
        run_pair_t p0;
        run_pair_t p1;
        int        n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata = S_DATA_W'($urandom);
            s_tlast = 1'($urandom_range(1));
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = S_DATA_W'(smp);
        s_tlast = lst;
        do
            @(posedge clk);
        while (!s_tready);
        n = encode_sample(smp, lst, p0, p1);
        if (typed)
        begin
            n = int'(n_typed);
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            runs_due.push_back(p0);
        if (n > 1)
            runs_due.push_back(p1);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_block(input int len, input block_kind_t kind);
        logic [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0] slope;
        int                  i;
        smp = SAMPLE_W'($urandom);
        slope = SAMPLE_W'(int'($urandom_range(6)) - 3);
        // Ramps start near zero so that even the longest one never wraps.
        if (kind == BLK_RAMP)
            smp = SAMPLE_W'(int'($urandom_range(2000)) - 1000);
        for (i = 0; i < len; i++)
        begin
            case (kind)
                BLK_NOISE:
                    smp = SAMPLE_W'($urandom);
                BLK_RAMP:
                    if (i > 0)
                        smp = smp + slope;
                BLK_STEPS:
                begin
                    if ($urandom_range(5) == 0)
                        slope = SAMPLE_W'(int'($urandom_range(40)) - 20);
                    if (i > 0)
                        smp = smp + slope;
                end
                default:
                    case ($urandom_range(3))
                        0: smp = 16'h8000;
                        1: smp = 16'h7FFF;
                        2: smp = 16'h0000;
                        default: smp = 16'hFFFF;
                    endcase
            endcase
            offer_sample(smp, i == len - 1, 1'b0, 2'd0, NO_PAIR, NO_PAIR);
        end
        blocks_sent++;
    endtask

    task automatic random_blocks(input int n_items);
        int target;
        int pick;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_block(1, block_kind_t'($urandom_range(3)));
            else if (pick < 95)
                send_block($urandom_range(24, 2), block_kind_t'($urandom_range(3)));
            else
                send_block($urandom_range(120, 40), BLK_RAMP);
        end
    endtask

    // Receiver: random stalls, plus a long counted hold whenever one is asked for.
    initial
    begin
        int held;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                m_tready = 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                holds_done++;
            end
            else
                m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        run_pair_t             want;
        logic [DELTA_W-1:0]    got_delta;
        logic [COUNT_BITS-1:0] got_count;
        logic [M_DATA_W-DELTA_W-COUNT_BITS-1:0] got_fill;
        if (rst_n)
        begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready)
            begin
                pairs_seen++;
                got_delta = m_tdata[DELTA_W-1:0];
                got_count = m_tdata[DELTA_W +: COUNT_BITS];
                got_fill = m_tdata[M_DATA_W-1:DELTA_W+COUNT_BITS];
                if (runs_due.size() == 0)
                    report_mismatch($sformatf("pair (%0d, %0d) with nothing outstanding",
                                              $signed(got_delta), got_count));
                else
                begin
                    want = runs_due.pop_front();
                    if (got_delta !== want.delta)
                        report_mismatch($sformatf("run_delta %0d, wanted %0d",
                                                  $signed(got_delta), $signed(want.delta)));
                    if (got_count !== want.count)
                        report_mismatch($sformatf("run_count %0d, wanted %0d",
                                                  got_count, want.count));
                    if (m_tlast !== want.eob)
                        report_mismatch($sformatf("end_of_block %b, wanted %b",
                                                  m_tlast, want.eob));
                    if (got_fill !== '0)
                        report_mismatch($sformatf("tdata fill bits %h not zero", got_fill));
                    if (want.count == MAX_RUN)
                        full_runs++;
                    if (want.eob)
                        blocks_closed++;
                end
            end
        end
    end

    initial
    begin
        int r;
        int drain;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        prev_smp = '0;
        open_delta = '0;
        open_len = '0;
        open_run = 1'b0;
        want_base = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 17;
        recv_stall_pct = 17;
        for (r = 0; r < N_ROWS; r++)
            offer_sample(DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].lst, DIRECTED_ROWS[r].typed,
                         DIRECTED_ROWS[r].n_pairs, DIRECTED_ROWS[r].p0, DIRECTED_ROWS[r].p1);

        // Full rate; a long receiver hold at the start backs the queue up into the input.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holds_asked++;
        random_blocks(PHASE_ITEMS);
        // 256 equal deltas: a full run mid-block, then a fresh run of one closing the block.
        send_block(257, BLK_RAMP);

        send_idle_pct = 80;
        random_blocks(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_stall_pct = 80;
        random_blocks(PHASE_ITEMS);

        send_idle_pct = 17;
        recv_stall_pct = 17;
        // 255 equal deltas: the run limit lands on the last sample.
        send_block(256, BLK_RAMP);
        random_blocks(PHASE_ITEMS / 2);

        s_tvalid = 1'b0;
        drain = 0;
        while (runs_due.size() != 0 && drain < 50000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (runs_due.size() != 0)
            report_mismatch($sformatf("%0d pairs never arrived", runs_due.size()));

        $display("Sent %0d samples in %0d blocks; checked %0d pairs, %0d ending a block.",
                 items_sent, blocks_sent, pairs_seen, blocks_closed);
        $display("Full-length runs: %0d; cycles with the input held off: %0d.",
                 full_runs, input_stalls);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/drle_pkg.sv
rtl/drle_core.sv
rtl/drle_queue.sv
rtl/delta_run_length_encoder.sv
rtl/drle_checker.sv
tb/tb_delta_run_length_encoder.sv
